### src/fractal_escape_time_unit_assert.svh
// Assertion macros shared by the modules of the escape time unit.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef FRACTAL_ESCAPE_TIME_UNIT_ASSERT_SVH
`define FRACTAL_ESCAPE_TIME_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define FET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FET_ASSERT_IMP(lbl, ante, cons, msg)

`define FET_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### src/fet_pkg.sv
package fet_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 24;
  localparam int ITER_BITS   = 12;
  localparam int ESC_WIDTH   = 8;
  localparam int MAG_WIDTH   = FRAC_BITS + ESC_WIDTH;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = ITER_BITS;
  localparam int POWER_W     = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [ITER_BITS-1:0]          iter_t;
  typedef logic [1:0]                    opd_t;
  typedef logic [1:0]                    tag_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  localparam cfg_idx_t REG_POWER     = 2'd0;
  localparam cfg_idx_t REG_MAX_ITER  = 2'd1;
  localparam cfg_idx_t REG_BIN_DECOMP = 2'd2;
  localparam cfg_idx_t REG_ESCAPE_SQ = 2'd3;

  localparam logic [POWER_W-1:0]   POWER_RST    = 3'd2;
  localparam iter_t                MAX_ITER_RST = ITER_BITS'(300);
  localparam logic [ESC_WIDTH-1:0] ESCAPE_RST   = 8'd13;

  // Multiplier operand sources.
  localparam opd_t OPD_ZR = 2'd0;
  localparam opd_t OPD_ZI = 2'd1;
  localparam opd_t OPD_SR = 2'd2;
  localparam opd_t OPD_SI = 2'd3;

  // Product slots: real*real, imag*imag, real*imag, imag*real.
  localparam tag_t TAG_RR = 2'd0;
  localparam tag_t TAG_II = 2'd1;
  localparam tag_t TAG_RI = 2'd2;
  localparam tag_t TAG_IR = 2'd3;

  typedef struct packed {
    coord_t c_real;
    coord_t c_imag;
  } in_item_t;

  typedef struct packed {
    iter_t iter_count;
    logic  inside_res;
  } out_item_t;

  typedef struct packed {
    opd_t a_sel;
    opd_t b_sel;
    tag_t tag;
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    issue;
    mul_op_t op;
    logic    do_s;
    logic    s_sym;
    logic    do_c;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_rdy;
    logic mul_done;
    logic escape;
    logic zi_pos;
  } dp_sts_t;

endpackage

### src/fet_mul.sv
`include "fractal_escape_time_unit_assert.svh"

module fet_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  fet_pkg::coord_t               a,
  input  fet_pkg::coord_t               b,
  input  fet_pkg::tag_t                 tag_i,
  output logic                          rdy,
  output logic                          done,
  output fet_pkg::tag_t                 tag_o,
  output fet_pkg::coord_t               coord,
  output logic [fet_pkg::MAG_WIDTH-1:0] mag
);

  localparam int CW   = fet_pkg::COORD_WIDTH;
  localparam int FRAC = fet_pkg::FRAC_BITS;
  localparam int MAGW = fet_pkg::MAG_WIDTH;
  localparam int NP   = (CW > 32) ? 2 : 1;
  localparam int HW   = (CW + NP - 1) / NP;
  localparam int PW   = CW + NP * HW;
  localparam int QW   = PW - FRAC;
  localparam int XW0  = (QW > MAGW) ? QW : MAGW;
  localparam int XW   = ((XW0 > CW) ? XW0 : CW) + 1;

  localparam logic [XW-1:0] HALF    = XW'(1) << (CW - 1);
  localparam logic [XW-1:0] HALF_M1 = HALF - XW'(1);
  localparam logic [XW-1:0] MAG_OVF = XW'(1) << MAGW;

  logic               busy_r, busy_nxt;
  logic               pass_r, pass_nxt;
  logic               last_pass;
  logic [CW-1:0]      ma_in, mb_in;
  logic [CW-1:0]      ma_r, mb_r;
  logic               neg_r;
  fet_pkg::tag_t      tag_r;

  logic [NP*HW-1:0]   mb_pad;
  logic [HW-1:0]      chunk;
  logic               pp_v_r, pp_pass_r, pp_last_r, pp_neg_r;
  logic [CW+HW-1:0]   pp_r;
  fet_pkg::tag_t      pp_tag_r;

  logic [PW-1:0]      acc_r, acc_base, acc_add;
  logic               fin_v_r, fin_neg_r;
  fet_pkg::tag_t      fin_tag_r;

  logic [XW-1:0]      q_x;
  logic [CW-1:0]      coord_c;
  logic [MAGW-1:0]    mag_c;
  logic               done_r;
  fet_pkg::coord_t    coord_r;
  logic [MAGW-1:0]    mag_r;
  fet_pkg::tag_t      tag_o_r;

  assign last_pass = (pass_r == 1'(NP - 1));
  assign rdy       = !busy_r || last_pass;
  assign ma_in     = a[CW-1] ? (~a + 1'b1) : a;
  assign mb_in     = b[CW-1] ? (~b + 1'b1) : b;

  always_comb begin
    busy_nxt = busy_r;
    pass_nxt = pass_r;
    if (start) begin
      busy_nxt = 1'b1;
      pass_nxt = 1'b0;
    end else if (busy_r) begin
      if (last_pass) begin
        busy_nxt = 1'b0;
      end else begin
        pass_nxt = pass_r + 1'b1;
      end
    end
  end

  assign mb_pad = (NP * HW)'(mb_r);
  assign chunk  = HW'(mb_pad >> (HW * pass_r));

  assign acc_base = (pp_pass_r == 1'b0) ? '0 : acc_r;
  assign acc_add  = PW'(pp_r) << (HW * pp_pass_r);

  assign q_x = XW'(acc_r >> FRAC);

  always_comb begin
    if (!fin_neg_r) begin
      coord_c = (q_x > HALF_M1) ? {1'b0, {(CW-1){1'b1}}} : q_x[CW-1:0];
    end else begin
      coord_c = (q_x > HALF) ? {1'b1, {(CW-1){1'b0}}} : (~q_x[CW-1:0] + 1'b1);
    end
    mag_c = (q_x >= MAG_OVF) ? {MAGW{1'b1}} : q_x[MAGW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pass_r  <= 1'b0;
      pp_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      pass_r  <= pass_nxt;
      pp_v_r  <= busy_r;
      fin_v_r <= pp_v_r && pp_last_r;
      done_r  <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= ma_in;
      mb_r  <= mb_in;
      neg_r <= a[CW-1] ^ b[CW-1];
      tag_r <= tag_i;
    end
    pp_r      <= (CW+HW)'(ma_r) * (CW+HW)'(chunk);
    pp_pass_r <= pass_r;
    pp_last_r <= last_pass;
    pp_neg_r  <= neg_r;
    pp_tag_r  <= tag_r;
    if (pp_v_r) begin
      acc_r <= acc_base + acc_add;
    end
    if (pp_v_r && pp_last_r) begin
      fin_neg_r <= pp_neg_r;
      fin_tag_r <= pp_tag_r;
    end
    if (fin_v_r) begin
      coord_r <= coord_c;
      mag_r   <= mag_c;
      tag_o_r <= fin_tag_r;
    end
  end

  assign done  = done_r;
  assign tag_o = tag_o_r;
  assign coord = coord_r;
  assign mag   = mag_r;

  `FET_ASSERT_IMP(a_start_when_ready, start, rdy, "product issued while multiplier busy")

endmodule

### src/fet_dp.sv
module fet_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fet_pkg::in_item_t             in_data,
  input  logic [fet_pkg::ESC_WIDTH-1:0] escape_sq,
  input  fet_pkg::dp_cmd_t              cmd,
  output fet_pkg::dp_sts_t              sts
);

  localparam int CW   = fet_pkg::COORD_WIDTH;
  localparam int FRAC = fet_pkg::FRAC_BITS;
  localparam int MAGW = fet_pkg::MAG_WIDTH;

  fet_pkg::coord_t cr_r, ci_r, zr_r, zi_r, sr_r, si_r;
  fet_pkg::coord_t p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [MAGW-1:0] m_rr_r, m_ii_r;

  fet_pkg::coord_t mul_a, mul_b, mul_coord;
  logic            mul_rdy, mul_done;
  fet_pkg::tag_t   mul_tag;
  logic [MAGW-1:0] mul_mag;
  logic [MAGW:0]   mag_sum, thr;

  function automatic fet_pkg::coord_t sat_add(input fet_pkg::coord_t x,
                                              input fet_pkg::coord_t y,
                                              input logic sub);
    logic [CW:0] s;
    s = sub ? ({x[CW-1], x} - {y[CW-1], y}) : ({x[CW-1], x} + {y[CW-1], y});
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return s[CW-1:0];
  endfunction

  function automatic fet_pkg::coord_t pick(input fet_pkg::opd_t sel,
                                           input fet_pkg::coord_t zr,
                                           input fet_pkg::coord_t zi,
                                           input fet_pkg::coord_t sr,
                                           input fet_pkg::coord_t si);
    fet_pkg::coord_t v;
    unique case (sel)
      fet_pkg::OPD_ZR: v = zr;
      fet_pkg::OPD_ZI: v = zi;
      fet_pkg::OPD_SR: v = sr;
      fet_pkg::OPD_SI: v = si;
      default:         v = zr;
    endcase
    return v;
  endfunction

  assign mul_a = pick(cmd.op.a_sel, zr_r, zi_r, sr_r, si_r);
  assign mul_b = pick(cmd.op.b_sel, zr_r, zi_r, sr_r, si_r);

  fet_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.issue),
    .a     (mul_a),
    .b     (mul_b),
    .tag_i (cmd.op.tag),
    .rdy   (mul_rdy),
    .done  (mul_done),
    .tag_o (mul_tag),
    .coord (mul_coord),
    .mag   (mul_mag)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r <= in_data.c_real;
      ci_r <= in_data.c_imag;
      zr_r <= in_data.c_real;
      zi_r <= in_data.c_imag;
    end else if (cmd.do_c) begin
      zr_r <= sat_add(sr_r, cr_r, 1'b0);
      zi_r <= sat_add(si_r, ci_r, 1'b0);
    end
    if (cmd.do_s) begin
      sr_r <= sat_add(p_rr_r, p_ii_r, 1'b1);
      si_r <= sat_add(p_ri_r, cmd.s_sym ? p_ri_r : p_ir_r, 1'b0);
    end
    if (mul_done) begin
      unique case (mul_tag)
        fet_pkg::TAG_RR: begin
          p_rr_r <= mul_coord;
          m_rr_r <= mul_mag;
        end
        fet_pkg::TAG_II: begin
          p_ii_r <= mul_coord;
          m_ii_r <= mul_mag;
        end
        fet_pkg::TAG_RI: p_ri_r <= mul_coord;
        fet_pkg::TAG_IR: p_ir_r <= mul_coord;
        default:         p_rr_r <= mul_coord;
      endcase
    end
  end

  assign mag_sum = {1'b0, m_rr_r} + {1'b0, m_ii_r};
  assign thr     = {1'b0, escape_sq, {FRAC{1'b0}}};

  assign sts.mul_rdy  = mul_rdy;
  assign sts.mul_done = mul_done;
  assign sts.escape   = (mag_sum >= thr);
  assign sts.zi_pos   = !zi_r[CW-1] && (zi_r != '0);

endmodule

### src/fet_ctrl.sv
`include "fractal_escape_time_unit_assert.svh"

module fet_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fet_pkg::POWER_W-1:0]     power,
  input  fet_pkg::iter_t                  max_iter,
  input  logic                            binary_decomp,
  output fet_pkg::dp_cmd_t                cmd,
  input  fet_pkg::dp_sts_t                sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fet_pkg::out_item_t              out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_POW   = 3'd4;
  localparam logic [2:0] S_ADDC  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [1:0] PH_Z  = 2'd0;
  localparam logic [1:0] PH_S3 = 2'd1;
  localparam logic [1:0] PH_S4 = 2'd2;

  localparam logic [1:0] PW_2 = 2'd0;
  localparam logic [1:0] PW_3 = 2'd1;
  localparam logic [1:0] PW_4 = 2'd2;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          ph_r, ph_nxt;
  logic [1:0]          pw_r, pw_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [2:0]          pend_r, pend_nxt;
  fet_pkg::iter_t      rep_r, rep_nxt;
  logic                tst_r, tst_nxt;
  fet_pkg::out_item_t  res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  fet_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                go_on;
  logic [1:0]          k_last;

  function automatic fet_pkg::mul_op_t sched(input logic [1:0] ph, input logic [1:0] k);
    fet_pkg::mul_op_t op;
    op = '{a_sel: fet_pkg::OPD_ZR, b_sel: fet_pkg::OPD_ZR, tag: fet_pkg::TAG_RR};
    unique case (ph)
      PH_S3: begin
        unique case (k)
          2'd0:    op = '{a_sel: fet_pkg::OPD_SR, b_sel: fet_pkg::OPD_ZR, tag: fet_pkg::TAG_RR};
          2'd1:    op = '{a_sel: fet_pkg::OPD_SI, b_sel: fet_pkg::OPD_ZI, tag: fet_pkg::TAG_II};
          2'd2:    op = '{a_sel: fet_pkg::OPD_SR, b_sel: fet_pkg::OPD_ZI, tag: fet_pkg::TAG_RI};
          default: op = '{a_sel: fet_pkg::OPD_SI, b_sel: fet_pkg::OPD_ZR, tag: fet_pkg::TAG_IR};
        endcase
      end
      PH_S4: begin
        unique case (k)
          2'd0:    op = '{a_sel: fet_pkg::OPD_SR, b_sel: fet_pkg::OPD_SR, tag: fet_pkg::TAG_RR};
          2'd1:    op = '{a_sel: fet_pkg::OPD_SI, b_sel: fet_pkg::OPD_SI, tag: fet_pkg::TAG_II};
          default: op = '{a_sel: fet_pkg::OPD_SR, b_sel: fet_pkg::OPD_SI, tag: fet_pkg::TAG_RI};
        endcase
      end
      default: begin
        unique case (k)
          2'd0:    op = '{a_sel: fet_pkg::OPD_ZR, b_sel: fet_pkg::OPD_ZR, tag: fet_pkg::TAG_RR};
          2'd1:    op = '{a_sel: fet_pkg::OPD_ZI, b_sel: fet_pkg::OPD_ZI, tag: fet_pkg::TAG_II};
          default: op = '{a_sel: fet_pkg::OPD_ZR, b_sel: fet_pkg::OPD_ZI, tag: fet_pkg::TAG_RI};
        endcase
      end
    endcase
    return op;
  endfunction

  assign k_last   = (ph_r == PH_S3) ? 2'd3 : 2'd2;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ph_nxt       = ph_r;
    pw_nxt       = pw_r;
    k_nxt        = k_r;
    rep_nxt      = rep_r;
    tst_nxt      = tst_r;
    res_nxt      = res_r;
    out_data_nxt = out_data_r;
    go_on        = 1'b0;
    cmd          = '0;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          rep_nxt  = '0;
          tst_nxt  = 1'b0;
          k_nxt    = 2'd0;
          ph_nxt   = PH_Z;
          priority if (power <= 3'd2) pw_nxt = PW_2;
          else if (power == 3'd3)     pw_nxt = PW_3;
          else                        pw_nxt = PW_4;
          if (max_iter == '0) begin
            res_nxt   = '{iter_count: '0, inside_res: 1'b1};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd.op    = sched(ph_r, k_r);
        cmd.issue = sts.mul_rdy;
        if (sts.mul_rdy) begin
          if (k_r == k_last) begin
            k_nxt     = 2'd0;
            state_nxt = S_WAIT;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_WAIT: begin
        if ((pend_r == 3'd0) || (pend_r == 3'd1 && sts.mul_done)) begin
          state_nxt = (ph_r == PH_Z) ? S_SQ : S_POW;
        end
      end
      S_SQ: begin
        cmd.do_s  = 1'b1;
        cmd.s_sym = 1'b1;
        go_on     = 1'b1;
        if (tst_r) begin
          priority if (sts.escape) begin
            res_nxt.iter_count = (binary_decomp && sts.zi_pos) ? (rep_r >> 1) : rep_r;
            res_nxt.inside_res = 1'b0;
            state_nxt          = S_DONE;
            go_on              = 1'b0;
          end else if (rep_r == max_iter - 1'b1) begin
            res_nxt.iter_count = max_iter;
            res_nxt.inside_res = 1'b1;
            state_nxt          = S_DONE;
            go_on              = 1'b0;
          end else begin
            rep_nxt = rep_r + 1'b1;
          end
        end
        if (go_on) begin
          if (pw_r == PW_2) begin
            state_nxt = S_ADDC;
          end else begin
            k_nxt     = 2'd0;
            ph_nxt    = (pw_r == PW_3) ? PH_S3 : PH_S4;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_POW: begin
        cmd.do_s  = 1'b1;
        cmd.s_sym = (ph_r == PH_S4);
        state_nxt = S_ADDC;
      end
      S_ADDC: begin
        cmd.do_c  = 1'b1;
        tst_nxt   = 1'b1;
        ph_nxt    = PH_Z;
        k_nxt     = 2'd0;
        state_nxt = S_ISSUE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign pend_nxt = pend_r + {2'b00, cmd.issue} - {2'b00, sts.mul_done};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 3'd0;
      out_valid_r <= 1'b0;
      ph_r        <= PH_Z;
      pw_r        <= PW_2;
      k_r         <= 2'd0;
      tst_r       <= 1'b0;
      rep_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
      pw_r        <= pw_nxt;
      k_r         <= k_nxt;
      tst_r       <= tst_nxt;
      rep_r       <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FET_ASSERT_IMP(a_done_has_pending, sts.mul_done, pend_r != 3'd0, "product returned with none outstanding")
  `FET_ASSERT_IMP(a_combine_drained, (state_r == S_SQ) || (state_r == S_POW), pend_r == 3'd0, "products combined before all returned")
  `FET_ASSERT_IMP(a_pending_bound, 1'b1, pend_r <= 3'd4, "more products in flight than one phase issues")

endmodule

### src/fractal_escape_time_unit.sv
// Escape-time unit for the map z = z^p + c (p of 2, 3 or 4), one point per item.
// A limit of zero returns a result of zero iterations, marked inside, without running
// any iteration. All products go through one shared multiplier that starts one real
// product per cycle: an iteration needs three products for z squared and its magnitude,
// plus three or four more for the higher powers, and the next iteration waits for all
// of them. One item is in flight at a time; the result waits in an output register so
// the next item can be taken at once.
module fractal_escape_time_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fet_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fet_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  fet_pkg::cfg_idx_t                  cfg_idx,
  input  logic [fet_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [fet_pkg::POWER_W-1:0]   power_r;
  fet_pkg::iter_t                max_iter_r;
  logic                          bin_decomp_r;
  logic [fet_pkg::ESC_WIDTH-1:0] escape_sq_r;

  fet_pkg::dp_cmd_t cmd;
  fet_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r      <= fet_pkg::POWER_RST;
      max_iter_r   <= fet_pkg::MAX_ITER_RST;
      bin_decomp_r <= 1'b0;
      escape_sq_r  <= fet_pkg::ESCAPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx)
        fet_pkg::REG_POWER:      power_r      <= cfg_wdata[fet_pkg::POWER_W-1:0];
        fet_pkg::REG_MAX_ITER:   max_iter_r   <= cfg_wdata[fet_pkg::ITER_BITS-1:0];
        fet_pkg::REG_BIN_DECOMP: bin_decomp_r <= cfg_wdata[0];
        fet_pkg::REG_ESCAPE_SQ:  escape_sq_r  <= cfg_wdata[fet_pkg::ESC_WIDTH-1:0];
        default:                 power_r      <= power_r;
      endcase
    end
  end

  fet_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .power         (power_r),
    .max_iter      (max_iter_r),
    .binary_decomp (bin_decomp_r),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

  fet_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .escape_sq (escape_sq_r),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam longint COORD_HI = (longint'(1) <<< (fet_pkg::COORD_WIDTH - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam longint unsigned MAG_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam int unsigned STEP_BUDGET = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fet_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fet_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  fet_pkg::cfg_idx_t cfg_idx = fet_pkg::REG_POWER;
  logic [fet_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [fet_pkg::POWER_W-1:0] reg_power = fet_pkg::POWER_RST;
  fet_pkg::iter_t reg_max_iter = fet_pkg::MAX_ITER_RST;
  logic reg_decomp = 1'b0;
  logic [fet_pkg::ESC_WIDTH-1:0] reg_escape = fet_pkg::ESCAPE_RST;

  fet_pkg::out_item_t predicted_escapes[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  fractal_escape_time_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic longint unsigned abs_val(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned scaled_prod(longint unsigned a, longint unsigned b);
    longint unsigned p;
    p = (a * b) >> fet_pkg::FRAC_BITS;
    return (p > MAG_LIMIT) ? MAG_LIMIT : p;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned m;
    m = scaled_prod(abs_val(a), abs_val(b));
    return clamp_coord(((a < 0) != (b < 0)) ? -longint'(m) : longint'(m));
  endfunction

  function automatic void cplx_mul(input longint ar, input longint ai, input longint br,
                                   input longint bi, output longint re_o, output longint im_o);
    re_o = clamp_coord(fx_mul(ar, br) - fx_mul(ai, bi));
    im_o = clamp_coord(fx_mul(ar, bi) + fx_mul(ai, br));
  endfunction

  // The steps output is the number of iterations the block has to run.
  function automatic fet_pkg::out_item_t escape_time(input fet_pkg::in_item_t pt,
                                                     output int unsigned steps);
    longint cr, ci, zr, zi, sr, si;
    longint unsigned sq, thr;
    int unsigned lim, n, eff_pow;
    fet_pkg::out_item_t res;
    cr = pt.c_real;
    ci = pt.c_imag;
    zr = cr;
    zi = ci;
    lim = reg_max_iter;
    thr = longint'(reg_escape) << fet_pkg::FRAC_BITS;
    eff_pow = (reg_power < 2) ? 2 : (reg_power > 4) ? 4 : reg_power;
    res.iter_count = reg_max_iter;
    res.inside_res = 1'b1;
    steps = lim;
    for (n = 0; n < lim; n++) begin
      cplx_mul(zr, zi, zr, zi, sr, si);
      if (eff_pow == 3) begin
        cplx_mul(sr, si, zr, zi, sr, si);
      end else if (eff_pow == 4) begin
        cplx_mul(sr, si, sr, si, sr, si);
      end
      zr = clamp_coord(sr + cr);
      zi = clamp_coord(si + ci);
      sq = scaled_prod(abs_val(zr), abs_val(zr)) + scaled_prod(abs_val(zi), abs_val(zi));
      if (sq >= thr) begin
        res.inside_res = 1'b0;
        res.iter_count = fet_pkg::iter_t'(n);
        if (reg_decomp && zi > 0) begin
          res.iter_count = fet_pkg::iter_t'((lim + n / 2) % lim);
        end
        steps = n + 1;
        break;
      end
    end
    return res;
  endfunction

  function automatic fet_pkg::in_item_t point(real re, real im);
    fet_pkg::in_item_t pt;
    pt.c_real = fet_pkg::coord_t'(longint'(re * (2.0 ** fet_pkg::FRAC_BITS)));
    pt.c_imag = fet_pkg::coord_t'(longint'(im * (2.0 ** fet_pkg::FRAC_BITS)));
    return pt;
  endfunction

  function automatic fet_pkg::in_item_t random_point();
    fet_pkg::in_item_t pt;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      pt.c_real = fet_pkg::coord_t'($urandom);
      pt.c_imag = fet_pkg::coord_t'($urandom);
    end else if (kind == 1) begin
      pt.c_real = fet_pkg::coord_t'(int'($urandom_range(0, 16)) - 8);
      pt.c_imag = fet_pkg::coord_t'(int'($urandom_range(0, 16)) - 8);
    end else begin
      pt.c_real = fet_pkg::coord_t'(int'($urandom_range(0, 54_000_000)) - 37_000_000);
      pt.c_imag = fet_pkg::coord_t'(int'($urandom_range(0, 44_000_000)) - 22_000_000);
    end
    return pt;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    fet_pkg::out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_escapes.size() == 0) begin
        $error("result with no pending point: iter_count %0d inside_res %0d",
               out_data.iter_count, out_data.inside_res);
        error_count++;
      end else begin
        exp_res = predicted_escapes.pop_front();
        if (out_data.iter_count !== exp_res.iter_count) begin
          $error("iter_count mismatch: expected %0d, actual %0d",
                 exp_res.iter_count, out_data.iter_count);
          error_count++;
        end
        if (out_data.inside_res !== exp_res.inside_res) begin
          $error("inside_res mismatch: expected %0d, actual %0d",
                 exp_res.inside_res, out_data.inside_res);
          error_count++;
        end
      end
    end
  end

  // Result-side stall generator, including long hold-offs.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_point(fet_pkg::in_item_t pt);
    int unsigned steps;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
    end
    in_data = pt;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted_escapes.push_back(escape_time(pt, steps));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (predicted_escapes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(fet_pkg::cfg_idx_t idx, logic [fet_pkg::CFG_DATA_W-1:0] val);
    cfg_idx = idx;
    cfg_wdata = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fet_pkg::REG_POWER: begin
        reg_power = val[fet_pkg::POWER_W-1:0];
      end
      fet_pkg::REG_MAX_ITER: begin
        reg_max_iter = val;
      end
      fet_pkg::REG_BIN_DECOMP: begin
        reg_decomp = val[0];
      end
      fet_pkg::REG_ESCAPE_SQ: begin
        reg_escape = val[fet_pkg::ESC_WIDTH-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(logic [fet_pkg::CFG_DATA_W-1:0] pw,
                                logic [fet_pkg::CFG_DATA_W-1:0] lim,
                                logic [fet_pkg::CFG_DATA_W-1:0] decomp,
                                logic [fet_pkg::CFG_DATA_W-1:0] esc);
    wait_idle();
    write_reg(fet_pkg::REG_POWER, pw);
    write_reg(fet_pkg::REG_MAX_ITER, lim);
    write_reg(fet_pkg::REG_BIN_DECOMP, decomp);
    write_reg(fet_pkg::REG_ESCAPE_SQ, esc);
  endtask

  task automatic test_reset_values();
    send_point(point(0.0, 0.0));
    send_point(point(2.0, 0.0));
    send_point(point(-0.75, 0.1));
  endtask

  task automatic test_field_extremes();
    fet_pkg::in_item_t pt;
    apply_settings(2, 16, 0, 13);
    pt.c_real = fet_pkg::coord_t'(COORD_HI);
    pt.c_imag = fet_pkg::coord_t'(COORD_HI);
    send_point(pt);
    pt.c_real = fet_pkg::coord_t'(COORD_LO);
    pt.c_imag = fet_pkg::coord_t'(COORD_LO);
    send_point(pt);
    pt.c_real = fet_pkg::coord_t'(COORD_LO);
    pt.c_imag = fet_pkg::coord_t'(COORD_HI);
    send_point(pt);
    pt.c_real = fet_pkg::coord_t'(COORD_HI);
    pt.c_imag = fet_pkg::coord_t'(COORD_LO);
    send_point(pt);
    pt.c_real = fet_pkg::coord_t'(1);
    pt.c_imag = fet_pkg::coord_t'(-1);
    send_point(pt);
    pt.c_real = fet_pkg::coord_t'(-1);
    pt.c_imag = fet_pkg::coord_t'(-1);
    send_point(pt);
  endtask

  task automatic test_power_settings();
    for (logic [fet_pkg::CFG_DATA_W-1:0] p = '0; p < 8; p++) begin
      apply_settings(p, 24, 0, 4);
      send_point(point(-0.5, 0.6));
    end
  endtask

  task automatic test_limit_extremes();
    apply_settings(2, 0, 0, 13);
    send_point(point(0.5, 0.5));
    apply_settings(3, 20, 1, 0);
    send_point(point(0.1, 0.2));
    apply_settings(4, 1, 0, 255);
    send_point(point(10.0, 10.0));
    apply_settings(2, 4095, 0, 1);
    send_point(point(0.0, 0.0));
  endtask

  task automatic test_binary_decomposition();
    apply_settings(2, 50, 1, 4);
    send_point(point(0.3, 0.6));
    send_point(point(0.3, -0.6));
    send_point(point(-2.0, 1.2));
  endtask

  // The block holds one point in flight and one finished result, so a long
  // result-side hold-off soon stalls the input while points keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    apply_settings(2, 3, 0, 13);
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    for (int n = 0; n < 10; n++) begin
      send_point(random_point());
    end
  endtask

  task automatic test_random_mode(int send_pct, int recv_pct, int n_items);
    int sent, chunk, pick, tries;
    int unsigned steps, pw, lim, esc;
    fet_pkg::in_item_t pt;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      pw = (pick < 7) ? 2 + pick % 3 : $urandom_range(0, 7);
      pick = $urandom_range(0, 29);
      lim = (pick == 0) ? 0 : (pick < 5) ? $urandom_range(65, 4095) : $urandom_range(1, 48);
      esc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(2, 20);
      apply_settings({9'($urandom), 3'(pw)}, 12'(lim), {11'($urandom), 1'($urandom)},
                     {4'($urandom), 8'(esc)});
      chunk = $urandom_range(8, 20);
      for (int n = 0; n < chunk; n++) begin
        pt = random_point();
        // Long limits are paired with points that leave early to bound run time.
        if (reg_max_iter > STEP_BUDGET) begin
          tries = 0;
          void'(escape_time(pt, steps));
          while (steps > STEP_BUDGET && tries < 8) begin
            pt = random_point();
            void'(escape_time(pt, steps));
            tries++;
          end
        end
        send_point(pt);
      end
      sent += chunk;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_field_extremes();
    test_power_settings();
    test_limit_extremes();
    test_binary_decomposition();
    test_backpressure();
    test_random_mode(0, 0, 120);
    test_random_mode(57, 0, 120);
    test_random_mode(0, 57, 120);
    test_random_mode(19, 19, 120);
    wait_idle();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### fractal_escape_time_unit.f
+incdir+src
src/fet_pkg.sv
src/fet_mul.sv
src/fet_dp.sv
src/fet_ctrl.sv
src/fractal_escape_time_unit.sv
verif/testbench.sv
